>>> hdl/flac_fhp_pkg.sv
// Shared types, constants and helper functions for the FLAC frame header parser.
// No dependencies; used by every module of the parser.
package flac_fhp_pkg;

    // Result status codes
    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_SYNC        = 4'd1,
        ST_BLOCK_SIZE  = 4'd2,
        ST_DEPTH       = 4'd3,
        ST_HEADER      = 4'd4,
        ST_RATE        = 4'd5,
        ST_CRC         = 4'd6,
        ST_CHANNELS    = 4'd7,
        ST_MISMATCH    = 4'd8
    } fhp_status_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_SAMPLE_RATE = 2'd0,
        CFG_CHANNELS    = 2'd1,
        CFG_SAMPLE_BITS = 2'd2,
        CFG_CRC_ENABLE  = 2'd3
    } fhp_cfg_idx_t;

    localparam int CFG_DATA_W = 20;

    localparam logic [19:0] RST_SAMPLE_RATE = 20'd44100;
    localparam logic [3:0]  RST_CHANNELS    = 4'd2;
    localparam logic [5:0]  RST_SAMPLE_BITS = 6'd16;
    localparam logic        RST_CRC_ENABLE  = 1'b1;

    // Stream settings
    typedef struct packed {
        logic [19:0] rate_hz;
        logic [3:0]  channels;
        logic [5:0]  sample_bits;
        logic        crc_enable;
    } fhp_cfg_t;

    // Header view after the current byte has been captured
    typedef struct packed {
        logic [5:0]      n_bytes;        // bytes received including current one
        logic [7:0]      size_rate_byte;
        logic [7:0]      channel_depth_byte;
        logic [4:0]      expected_length;
        logic            continuation_bad;
        logic [7:0]      crc_before;     // CRC over every byte before the current one
        logic [7:0]      crc_field;      // the current byte
        logic [3:0][7:0] extra_bytes;
        logic            length_report;  // current byte is the coded number lead byte
    } fhp_view_t;

    // Final check outcome
    typedef struct packed {
        fhp_status_t status;
        logic [4:0]  header_length;
        logic [16:0] block_len;
        logic [19:0] frame_rate;
        logic [3:0]  channel_code;
        logic [5:0]  sample_bits;
    } fhp_result_t;

    // CRC-8, polynomial 0x07, MSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ 8'h07) : (c << 1);
        end
        return c;
    endfunction

    // Length of the UTF-8 style coded number, 0 when the lead byte is invalid
    function automatic logic [2:0] coded_len(input logic [7:0] lead, input logic blocking);
        logic [2:0] len;
        priority if (!lead[7])                    len = 3'd1;
        else if (!lead[6] || (lead == 8'hFF))     len = 3'd0;
        else if (!lead[5])                        len = 3'd2;
        else if (!lead[4])                        len = 3'd3;
        else if (!lead[3])                        len = 3'd4;
        else if (!lead[2])                        len = 3'd5;
        else if (!lead[1])                        len = 3'd6;
        else                                      len = blocking ? 3'd7 : 3'd0;
        return len;
    endfunction

    // Extra bytes that follow the coded number for block size and rate
    function automatic logic [1:0] blk_extra(input logic [7:0] srb);
        logic [1:0] e;
        unique case (srb[7:4])
            4'd6:    e = 2'd1;
            4'd7:    e = 2'd2;
            default: e = 2'd0;
        endcase
        return e;
    endfunction

    function automatic logic [1:0] rate_extra(input logic [7:0] srb);
        logic [1:0] e;
        unique case (srb[3:0])
            4'd12:       e = 2'd1;
            4'd13, 4'd14: e = 2'd2;
            default:     e = 2'd0;
        endcase
        return e;
    endfunction

    // Block size table
    function automatic logic [15:0] blk_table(input logic [3:0] code);
        logic [15:0] v;
        unique case (code)
            4'd1:    v = 16'd192;
            4'd2:    v = 16'd576;
            4'd3:    v = 16'd1152;
            4'd4:    v = 16'd2304;
            4'd5:    v = 16'd4608;
            4'd8:    v = 16'd256;
            4'd9:    v = 16'd512;
            4'd10:   v = 16'd1024;
            4'd11:   v = 16'd2048;
            4'd12:   v = 16'd4096;
            4'd13:   v = 16'd8192;
            4'd14:   v = 16'd16384;
            4'd15:   v = 16'd32768;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    // Sample rate table
    function automatic logic [19:0] rate_table(input logic [3:0] code);
        logic [19:0] v;
        unique case (code)
            4'd1:    v = 20'd88200;
            4'd2:    v = 20'd176400;
            4'd3:    v = 20'd192000;
            4'd4:    v = 20'd8000;
            4'd5:    v = 20'd16000;
            4'd6:    v = 20'd22050;
            4'd7:    v = 20'd24000;
            4'd8:    v = 20'd32000;
            4'd9:    v = 20'd44100;
            4'd10:   v = 20'd48000;
            4'd11:   v = 20'd96000;
            default: v = 20'd0;
        endcase
        return v;
    endfunction

    // Bit depth table
    function automatic logic [5:0] depth_table(input logic [2:0] code);
        logic [5:0] v;
        unique case (code)
            3'd1:    v = 6'd8;
            3'd2:    v = 6'd12;
            3'd4:    v = 6'd16;
            3'd5:    v = 6'd20;
            3'd6:    v = 6'd24;
            3'd7:    v = 6'd32;
            default: v = 6'd0;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/flac_frame_header_parser_core.sv
// Top level of the FLAC frame header parser: stream settings registers,
// handshake and result register. Depends on flac_fhp_pkg, flac_fhp_capture, flac_fhp_check.
//
//   Channel  | Handshake                    | Payload
//   ---------+------------------------------+-------------------------------------------
//   bytes    | byte_valid / byte_stall      | header_byte, last_byte
//   results  | result_valid / result_stall  | result_kind, status, header_length,
//            |                              | block_len, frame_rate, channel_code,
//            |                              | sample_bits
//   config   | cfg_write                    | cfg_index, cfg_data
//
// One byte per clock while byte_stall is low; a result appears in the cycle after the byte that causes it.
// Throughput is set by the single result register: a byte is taken whenever that
// register is empty or being drained in the same cycle.
// Reset clears the header state and loads the stream settings defaults.
// byte_stall is high only while a result waits under result_stall.
module flac_frame_header_parser_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  byte_valid,
    output logic                                  byte_stall,
    input  logic [7:0]                            header_byte,
    input  logic                                  last_byte,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output logic                                  result_kind,
    output logic [3:0]                            status,
    output logic [4:0]                            header_length,
    output logic [16:0]                           block_len,
    output logic [19:0]                           frame_rate,
    output logic [3:0]                            channel_code,
    output logic [5:0]                            sample_bits,
    input  logic                                  cfg_write,
    input  logic [1:0]                            cfg_index,
    input  logic [flac_fhp_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import flac_fhp_pkg::*;

    fhp_cfg_t    cfg_reg;
    fhp_view_t   view;
    fhp_result_t check_res;

    logic        accept;
    logic        emit;
    logic        out_valid_reg, out_valid_next;
    logic        kind_reg;
    fhp_result_t res_reg, res_next;

    assign byte_stall = out_valid_reg && result_stall;
    assign accept     = byte_valid && !byte_stall;
    assign emit       = last_byte || view.length_report;

    // Stream settings
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rate_hz     <= RST_SAMPLE_RATE;
            cfg_reg.channels    <= RST_CHANNELS;
            cfg_reg.sample_bits <= RST_SAMPLE_BITS;
            cfg_reg.crc_enable  <= RST_CRC_ENABLE;
        end
        else if (cfg_write)
        begin
            unique case (fhp_cfg_idx_t'(cfg_index))
                CFG_SAMPLE_RATE: cfg_reg.rate_hz     <= cfg_data[19:0];
                CFG_CHANNELS:    cfg_reg.channels    <= cfg_data[3:0];
                CFG_SAMPLE_BITS: cfg_reg.sample_bits <= cfg_data[5:0];
                CFG_CRC_ENABLE:  cfg_reg.crc_enable  <= cfg_data[0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    flac_fhp_capture u_capture (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .header_byte (header_byte),
        .last_byte   (last_byte),
        .view        (view)
    );

    flac_fhp_check u_check (
        .view   (view),
        .cfg    (cfg_reg),
        .result (check_res)
    );

    // Result selection: final result, or the length report after the lead byte
    always_comb
    begin
        if (last_byte)
        begin
            res_next = check_res;
        end
        else
        begin
            res_next                    = '0;
            res_next.status             = ST_OK;
            res_next.header_length      = view.expected_length;
        end
    end

    assign out_valid_next = byte_stall ? 1'b1 : (accept && emit);

    // Result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Result payload, loaded on each transfer that yields a result
    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            res_reg  <= res_next;
            kind_reg <= last_byte;
        end
    end

    assign result_valid  = out_valid_reg;
    assign result_kind   = kind_reg;
    assign status        = res_reg.status;
    assign header_length = res_reg.header_length;
    assign block_len     = res_reg.block_len;
    assign frame_rate    = res_reg.frame_rate;
    assign channel_code  = res_reg.channel_code;
    assign sample_bits   = res_reg.sample_bits;

endmodule

>>> hdl/flac_fhp_capture.sv
// Per-byte header capture: byte counter, field bytes, coded number checks,
// extra bytes and running CRC-8. Depends on flac_fhp_pkg.
module flac_fhp_capture (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic [7:0]              header_byte,
    input  logic                    last_byte,
    output flac_fhp_pkg::fhp_view_t view
);
    import flac_fhp_pkg::*;

    logic [4:0]      byte_count_reg, byte_count_next;
    logic            blocking_bit_reg, blocking_bit_next;
    logic [7:0]      size_rate_byte_reg, size_rate_byte_next;
    logic [7:0]      channel_depth_byte_reg, channel_depth_byte_next;
    logic [7:0]      coded_lead_byte_reg, coded_lead_byte_next;
    logic [4:0]      expected_length_reg, expected_length_next;
    logic [7:0]      running_crc_reg, running_crc_next;
    logic            continuation_bad_reg, continuation_bad_next;
    logic [3:0][7:0] extra_bytes_reg;

    logic [2:0] cl_new;
    logic [2:0] cl_stored;
    logic [3:0] cont_end;
    logic [4:0] extra_off;
    logic       extra_we;

    // Coded number length from the new lead byte and from the stored one
    assign cl_new    = coded_len(header_byte, blocking_bit_reg);
    assign cl_stored = coded_len(coded_lead_byte_reg, blocking_bit_reg);
    assign cont_end  = 4'd4 + {1'b0, cl_stored};
    assign extra_off = byte_count_reg - {1'b0, cont_end};

    // Field capture for the current byte
    always_comb
    begin
        blocking_bit_next       = blocking_bit_reg;
        size_rate_byte_next     = size_rate_byte_reg;
        channel_depth_byte_next = channel_depth_byte_reg;
        coded_lead_byte_next    = coded_lead_byte_reg;
        expected_length_next    = expected_length_reg;
        continuation_bad_next   = continuation_bad_reg;
        extra_we                = 1'b0;
        if (byte_count_reg == 5'd1)
        begin
            blocking_bit_next = header_byte[0];
        end
        else if (byte_count_reg == 5'd2)
        begin
            size_rate_byte_next = header_byte;
        end
        else if (byte_count_reg == 5'd3)
        begin
            channel_depth_byte_next = header_byte;
        end
        else if (byte_count_reg == 5'd4)
        begin
            coded_lead_byte_next = header_byte;
            expected_length_next = (cl_new == 3'd0) ? 5'd0 :
                5'd5 + {2'b0, cl_new} + {3'b0, blk_extra(size_rate_byte_reg)}
                     + {3'b0, rate_extra(size_rate_byte_reg)};
        end
        else if ((byte_count_reg >= 5'd5) && (cl_stored != 3'd0))
        begin
            if (byte_count_reg < {1'b0, cont_end})
            begin
                if (header_byte[7:6] != 2'b10)
                    continuation_bad_next = 1'b1;
            end
            else if (extra_off < 5'd4)
            begin
                extra_we = 1'b1;
            end
        end
        running_crc_next = crc8_byte(running_crc_reg, header_byte);
        byte_count_next  = (byte_count_reg < 5'd31) ? byte_count_reg + 5'd1 : 5'd31;
    end

    // View after this byte, as used by the final check
    always_comb
    begin
        view.n_bytes            = {1'b0, byte_count_reg} + 6'd1;
        view.size_rate_byte     = size_rate_byte_next;
        view.channel_depth_byte = channel_depth_byte_next;
        view.expected_length    = expected_length_next;
        view.continuation_bad   = continuation_bad_next;
        view.crc_before         = running_crc_reg;
        view.crc_field          = header_byte;
        view.extra_bytes        = extra_bytes_reg;
        view.length_report      = (byte_count_reg == 5'd4);
    end

    // Control state; cleared after the last byte of a header
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg         <= '0;
            blocking_bit_reg       <= 1'b0;
            size_rate_byte_reg     <= '0;
            channel_depth_byte_reg <= '0;
            coded_lead_byte_reg    <= '0;
            expected_length_reg    <= '0;
            running_crc_reg        <= '0;
            continuation_bad_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                byte_count_reg         <= '0;
                blocking_bit_reg       <= 1'b0;
                size_rate_byte_reg     <= '0;
                channel_depth_byte_reg <= '0;
                coded_lead_byte_reg    <= '0;
                expected_length_reg    <= '0;
                running_crc_reg        <= '0;
                continuation_bad_reg   <= 1'b0;
            end
            else
            begin
                byte_count_reg         <= byte_count_next;
                blocking_bit_reg       <= blocking_bit_next;
                size_rate_byte_reg     <= size_rate_byte_next;
                channel_depth_byte_reg <= channel_depth_byte_next;
                coded_lead_byte_reg    <= coded_lead_byte_next;
                expected_length_reg    <= expected_length_next;
                running_crc_reg        <= running_crc_next;
                continuation_bad_reg   <= continuation_bad_next;
            end
        end
    end

    // Extra bytes after the coded number (payload, no reset)
    always_ff @(posedge clk)
    begin
        if (accept && extra_we)
            extra_bytes_reg[extra_off[1:0]] <= header_byte;
    end

endmodule

>>> hdl/flac_fhp_check.sv
// Final header check: decodes block size, rate and depth and applies the
// checks in priority order. Pure logic. Depends on flac_fhp_pkg.
module flac_fhp_check (
    input  flac_fhp_pkg::fhp_view_t   view,
    input  flac_fhp_pkg::fhp_cfg_t    cfg,
    output flac_fhp_pkg::fhp_result_t result
);
    import flac_fhp_pkg::*;

    logic [3:0]  bcode;
    logic [3:0]  rcode;
    logic [3:0]  ca;
    logic [2:0]  dcode;
    logic [5:0]  depth_val;
    logic [5:0]  bits;
    logic [1:0]  off;
    logic [1:0]  off1;
    logic [7:0]  rate_hi;
    logic [7:0]  rate_lo;
    logic [16:0] blk;
    logic [19:0] rate;
    logic [3:0]  chans;
    logic [15:0] rate_pair;
    fhp_status_t status;

    assign bcode = view.size_rate_byte[7:4];
    assign rcode = view.size_rate_byte[3:0];
    assign ca    = view.channel_depth_byte[7:4];
    assign dcode = view.channel_depth_byte[3:1];

    // Field decode
    always_comb
    begin
        depth_val = depth_table(dcode);
        bits      = (dcode == 3'd0) ? cfg.sample_bits : depth_val;

        off  = blk_extra(view.size_rate_byte);
        off1 = off + 2'd1;
        rate_hi   = view.extra_bytes[off];
        rate_lo   = view.extra_bytes[off1];
        rate_pair = {rate_hi, rate_lo};

        unique case (bcode)
            4'd6:    blk = {9'b0, view.extra_bytes[0]} + 17'd1;
            4'd7:    blk = {1'b0, view.extra_bytes[0], view.extra_bytes[1]} + 17'd1;
            default: blk = {1'b0, blk_table(bcode)};
        endcase

        unique case (rcode)
            4'd0:    rate = cfg.rate_hz;
            4'd12:   rate = {2'b0, 18'({10'b0, rate_hi} * 18'd1000)};
            4'd13:   rate = {4'b0, rate_pair};
            4'd14:   rate = 20'({4'b0, rate_pair} * 20'd10);
            default: rate = rate_table(rcode);
        endcase

        chans = (ca <= 4'd7) ? ca + 4'd1 : 4'd2;
    end

    // Checks in priority order
    always_comb
    begin
        status = ST_OK;
        priority if (view.n_bytes < 6'd3)                        status = ST_HEADER;
        else if (view.size_rate_byte == 8'hFF)                   status = ST_SYNC;
        else if (bcode == 4'd0)                                  status = ST_BLOCK_SIZE;
        else if (view.n_bytes < 6'd4)                            status = ST_HEADER;
        else if (view.channel_depth_byte == 8'hFF)               status = ST_SYNC;
        else if ((dcode != 3'd0) && (depth_val == 6'd0))         status = ST_DEPTH;
        else if ((view.n_bytes < 6'd5) || (view.expected_length == 5'd0) ||
                 (view.n_bytes != {1'b0, view.expected_length})) status = ST_HEADER;
        else if (view.continuation_bad)                          status = ST_HEADER;
        else if (rcode == 4'd15)                                 status = ST_RATE;
        else if (cfg.crc_enable && (view.crc_field != view.crc_before))
                                                                 status = ST_CRC;
        else if (ca > 4'd10)                                     status = ST_CHANNELS;
        else if (chans != cfg.channels)                          status = ST_MISMATCH;
        else if ((dcode != 3'd0) && (bits != cfg.sample_bits))   status = ST_MISMATCH;
        else if (rate != cfg.rate_hz)                            status = ST_MISMATCH;
        else                                                     status = ST_OK;
    end

    // Fields are zero unless the header passed
    always_comb
    begin
        result.status = status;
        if (status == ST_OK)
        begin
            result.header_length = view.expected_length;
            result.block_len     = blk;
            result.frame_rate    = rate;
            result.channel_code  = ca;
            result.sample_bits   = bits;
        end
        else
        begin
            result.header_length = '0;
            result.block_len     = '0;
            result.frame_rate    = '0;
            result.channel_code  = '0;
            result.sample_bits   = '0;
        end
    end

endmodule
